FILE: sv/debounced_hysteresis_clamp_with_lpf_defines.svh
// Assertion macros for the debounced hysteresis clamp.
// Expects signals named clock and reset in the module that uses them.
`ifndef DEBOUNCED_HYSTERESIS_CLAMP_WITH_LPF_DEFINES_SVH
`define DEBOUNCED_HYSTERESIS_CLAMP_WITH_LPF_DEFINES_SVH

// same-cycle implication
`define DHC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/dhc_lpf_pkg.sv
// Shared constants for the debounced hysteresis clamp with low-pass filters.
// No dependencies.
package dhc_lpf_pkg;

   localparam int THRESH_W = 12;
   localparam int LEN_W    = 8;
   localparam int ALPHA_W  = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = 2;

   localparam logic [IDX_W-1:0] REG_HIGH_THR = 2'd0;
   localparam logic [IDX_W-1:0] REG_LOW_THR  = 2'd1;
   localparam logic [IDX_W-1:0] REG_DEB_LEN  = 2'd2;
   localparam logic [IDX_W-1:0] REG_ALPHA    = 2'd3;

   localparam logic [THRESH_W-1:0] HIGH_THR_RST = 12'd2731;
   localparam logic [THRESH_W-1:0] LOW_THR_RST  = 12'd2712;
   localparam logic [LEN_W-1:0]    DEB_LEN_RST  = 8'd4;
   localparam logic [ALPHA_W-1:0]  ALPHA_RST    = 16'd1607;

   typedef logic [LEN_W-1:0] run_type;

endpackage

FILE: sv/debounced_hysteresis_clamp_with_lpf.sv
// Each request passes the input register, then the result register; the result register holds while stalled.
// Throughput: one request per cycle unless rsp_ready stalls; req_ready drops when both registers hold data.
// Filter multiply (alpha x difference) and debounce counter update are computed in the same cycle.
// Reset (synchronous, active high) clears the gate, run counters, both filter
// accumulators and the pipeline valids, and restores the register defaults.
// Depends on dhc_lpf_pkg and debounced_hysteresis_clamp_with_lpf_defines.svh.
`include "debounced_hysteresis_clamp_with_lpf_defines.svh"

module debounced_hysteresis_clamp_with_lpf #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [SAMPLE_BITS-1:0]            req_volt_sample,
   input  logic [SAMPLE_BITS-1:0]            req_curr_sample,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_gate_on,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]  rsp_volt_filtered,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]  rsp_curr_filtered,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dhc_lpf_pkg::ADDR_W-1:0]    paddr,
   input  logic [dhc_lpf_pkg::DATA_W-1:0]    pwdata,
   output logic [dhc_lpf_pkg::DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int ACC_W   = SAMPLE_BITS + FRAC_BITS;
   localparam int ALPHA_W = dhc_lpf_pkg::ALPHA_W;
   localparam int THR_W   = dhc_lpf_pkg::THRESH_W;
   localparam int LEN_W   = dhc_lpf_pkg::LEN_W;
   localparam int CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   // ---------------- configuration registers ----------------
   logic [THR_W-1:0]   high_thr_ff;
   logic [THR_W-1:0]   low_thr_ff;
   logic [LEN_W-1:0]   deb_len_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               cfg_wr;
   logic [dhc_lpf_pkg::IDX_W-1:0] cfg_idx;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[dhc_lpf_pkg::IDX_W+1:2];
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= dhc_lpf_pkg::HIGH_THR_RST;
         low_thr_ff  <= dhc_lpf_pkg::LOW_THR_RST;
         deb_len_ff  <= dhc_lpf_pkg::DEB_LEN_RST;
         alpha_ff    <= dhc_lpf_pkg::ALPHA_RST;
      end else if (cfg_wr) begin
         case (cfg_idx)
            dhc_lpf_pkg::REG_HIGH_THR: high_thr_ff <= pwdata[THR_W-1:0];
            dhc_lpf_pkg::REG_LOW_THR:  low_thr_ff  <= pwdata[THR_W-1:0];
            dhc_lpf_pkg::REG_DEB_LEN:  deb_len_ff  <= pwdata[LEN_W-1:0];
            dhc_lpf_pkg::REG_ALPHA:    alpha_ff    <= pwdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         dhc_lpf_pkg::REG_HIGH_THR: prdata = dhc_lpf_pkg::DATA_W'(high_thr_ff);
         dhc_lpf_pkg::REG_LOW_THR:  prdata = dhc_lpf_pkg::DATA_W'(low_thr_ff);
         dhc_lpf_pkg::REG_DEB_LEN:  prdata = dhc_lpf_pkg::DATA_W'(deb_len_ff);
         dhc_lpf_pkg::REG_ALPHA:    prdata = dhc_lpf_pkg::DATA_W'(alpha_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_volt_ff;
   logic [SAMPLE_BITS-1:0] s1_curr_ff;
   logic                   rsp_valid_ff;
   logic                   out_free;
   logic                   advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_volt_ff <= req_volt_sample;
         s1_curr_ff <= req_curr_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------- low-pass filters ----------------
   // acc + floor(alpha * (x - acc) / 2^ALPHA_W), clamped to the accumulator range
   function automatic logic [ACC_W-1:0] lpf_next(
      input logic [ACC_W-1:0]       acc,
      input logic [SAMPLE_BITS-1:0] x,
      input logic [ALPHA_W-1:0]     alpha
   );
      logic signed [ACC_W:0]         diff;
      logic signed [ACC_W+ALPHA_W:0] prod;
      logic signed [ACC_W:0]         delta;
      logic signed [ACC_W+1:0]       sum;
      logic [ACC_W-1:0]              res;
      diff  = signed'({1'b0, x, {FRAC_BITS{1'b0}}}) - signed'({1'b0, acc});
      prod  = signed'({1'b0, alpha}) * diff;
      delta = prod[ALPHA_W +: ACC_W+1];
      sum   = signed'({2'b00, acc}) + signed'({delta[ACC_W], delta});
      if (sum[ACC_W+1]) begin
         res = '0;
      end else if (sum[ACC_W]) begin
         res = '1;
      end else begin
         res = sum[ACC_W-1:0];
      end
      return res;
   endfunction

   logic [ACC_W-1:0] volt_acc_ff;
   logic [ACC_W-1:0] curr_acc_ff;
   logic [ACC_W-1:0] volt_acc_in;
   logic [ACC_W-1:0] curr_acc_in;

   assign volt_acc_in = lpf_next(volt_acc_ff, s1_volt_ff, alpha_ff);
   assign curr_acc_in = lpf_next(curr_acc_ff, s1_curr_ff, alpha_ff);

   // ---------------- hysteresis and debounce ----------------
   logic                  gate_ff;
   logic                  gate_in;
   dhc_lpf_pkg::run_type  above_ff;
   dhc_lpf_pkg::run_type  above_in;
   dhc_lpf_pkg::run_type  below_ff;
   dhc_lpf_pkg::run_type  below_in;
   dhc_lpf_pkg::run_type  above_inc;
   dhc_lpf_pkg::run_type  below_inc;
   logic                  over_high;
   logic                  under_low;

   assign over_high = CMP_W'(s1_volt_ff) > CMP_W'(high_thr_ff);
   assign under_low = CMP_W'(s1_volt_ff) < CMP_W'(low_thr_ff);
   assign above_inc = above_ff + 1'b1;
   assign below_inc = below_ff + 1'b1;

   always_comb begin
      gate_in  = gate_ff;
      above_in = above_ff;
      below_in = below_ff;
      if (!gate_ff) begin
         if (over_high) begin
            below_in = '0;
            if (above_inc >= deb_len_ff) begin
               gate_in  = 1'b1;
               above_in = '0;
            end else begin
               above_in = above_inc;
            end
         end else begin
            above_in = '0;
         end
      end else begin
         if (under_low) begin
            above_in = '0;
            if (below_inc >= deb_len_ff) begin
               gate_in  = 1'b0;
               below_in = '0;
            end else begin
               below_in = below_inc;
            end
         end else begin
            below_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff     <= 1'b0;
         above_ff    <= '0;
         below_ff    <= '0;
         volt_acc_ff <= '0;
         curr_acc_ff <= '0;
      end else if (advance) begin
         gate_ff     <= gate_in;
         above_ff    <= above_in;
         below_ff    <= below_in;
         volt_acc_ff <= volt_acc_in;
         curr_acc_ff <= curr_acc_in;
      end
   end

   // ---------------- result register ----------------
   logic             rsp_gate_ff;
   logic [ACC_W-1:0] rsp_volt_ff;
   logic [ACC_W-1:0] rsp_curr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_gate_ff <= gate_in;
         rsp_volt_ff <= volt_acc_in;
         rsp_curr_ff <= curr_acc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gate_on       = rsp_gate_ff;
   assign rsp_volt_filtered = rsp_volt_ff;
   assign rsp_curr_filtered = rsp_curr_ff;

   // ---------------- assertions ----------------
   `DHC_ASSERT_NEXT(a_gate_holds, !advance, gate_ff == $past(gate_ff), "gate moved without a request")
   `DHC_ASSERT_NEXT(a_switch_clears, advance && (gate_in != gate_ff), (above_ff == '0) && (below_ff == '0), "gate switch left a run count")
   `DHC_ASSERT_NOW(a_off_no_below, !gate_ff, below_ff == '0, "below run counting while gate off")
   `DHC_ASSERT_NOW(a_on_no_above, gate_ff, above_ff == '0, "above run counting while gate on")
   `DHC_ASSERT_NEXT(a_result_loaded, advance, rsp_valid_ff && (rsp_gate_ff == gate_ff), "result not loaded with new gate state")

endmodule

FILE: sim/debounced_hysteresis_clamp_with_lpf_test.sv
// Self-checking bench for the debounced hysteresis brake gate with voltage/current low-pass filters.
// Holds its own filter and debounce predictor and checks every result; needs dhc_lpf_pkg and the
// debounced_hysteresis_clamp_with_lpf RTL.
module debounced_hysteresis_clamp_with_lpf_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W       = 12;
   localparam int ACC_W          = 28;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic             gate_on;
      logic [ACC_W-1:0] volt;
      logic [ACC_W-1:0] curr;
   } brake_reading_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [SAMPLE_W-1:0]              req_volt_sample;
   logic [SAMPLE_W-1:0]              req_curr_sample;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_gate_on;
   logic [ACC_W-1:0]                 rsp_volt_filtered;
   logic [ACC_W-1:0]                 rsp_curr_filtered;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [dhc_lpf_pkg::ADDR_W-1:0]   paddr;
   logic [dhc_lpf_pkg::DATA_W-1:0]   pwdata;
   logic [dhc_lpf_pkg::DATA_W-1:0]   prdata;
   logic                             pready;

   // predictor copy of the registers and state
   logic [dhc_lpf_pkg::THRESH_W-1:0] high_thr;
   logic [dhc_lpf_pkg::THRESH_W-1:0] low_thr;
   logic [dhc_lpf_pkg::LEN_W-1:0]    deb_len;
   logic [dhc_lpf_pkg::ALPHA_W-1:0]  alpha;
   logic                             gate;
   dhc_lpf_pkg::run_type             above_run;
   dhc_lpf_pkg::run_type             below_run;
   logic [ACC_W-1:0]                 volt_acc;
   logic [ACC_W-1:0]                 curr_acc;

   brake_reading_type pending_readings[$];
   int                errors;
   int                quiet_cycles;
   bit                idling;
   bit                long_hold;

   debounced_hysteresis_clamp_with_lpf dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_volt_sample   (req_volt_sample),
      .req_curr_sample   (req_curr_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gate_on       (rsp_gate_on),
      .rsp_volt_filtered (rsp_volt_filtered),
      .rsp_curr_filtered (rsp_curr_filtered),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // acc += alpha * (x - acc), product floored by the arithmetic shift
   function automatic logic [ACC_W-1:0] lpf_next(input logic [ACC_W-1:0] acc,
                                                input logic [SAMPLE_W-1:0] sample);
      longint diff;
      longint delta;
      longint sum;
      diff  = longint'({sample, 16'd0}) - longint'(acc);
      delta = (longint'(alpha) * diff) >>> 16;
      sum   = longint'(acc) + delta;
      return sum[ACC_W-1:0];
   endfunction

   function automatic brake_reading_type advance_brake(input logic [SAMPLE_W-1:0] v,
                                                       input logic [SAMPLE_W-1:0] c);
      volt_acc = lpf_next(volt_acc, v);
      curr_acc = lpf_next(curr_acc, c);
      if (!gate) begin
         if (v > high_thr) begin
            above_run = above_run + 1'b1;
            below_run = '0;
            if (above_run >= deb_len) begin
               gate      = 1'b1;
               above_run = '0;
            end
         end else begin
            above_run = '0;
         end
      end else begin
         if (v < low_thr) begin
            below_run = below_run + 1'b1;
            above_run = '0;
            if (below_run >= deb_len) begin
               gate      = 1'b0;
               below_run = '0;
            end
         end else begin
            below_run = '0;
         end
      end
      return '{gate, volt_acc, curr_acc};
   endfunction

   function automatic logic [SAMPLE_W-1:0] sample_above();
      if (high_thr == '1) return SAMPLE_W'($urandom_range(0, 4095));
      return SAMPLE_W'($urandom_range(high_thr + 1, 4095));
   endfunction

   function automatic logic [SAMPLE_W-1:0] sample_below();
      if (low_thr == '0) return SAMPLE_W'($urandom_range(0, 4095));
      return SAMPLE_W'($urandom_range(0, low_thr - 1));
   endfunction

   // predict on every accepted request, check every accepted result, watch for a hang
   always @(posedge clock) begin
      brake_reading_type got;
      brake_reading_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_readings.push_back(advance_brake(req_volt_sample, req_curr_sample));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_gate_on, rsp_volt_filtered, rsp_curr_filtered};
            if (pending_readings.size() == 0) begin
               $display("%0t: unexpected result gate=%0d volt=%0h curr=%0h",
                        $time, got.gate_on, got.volt, got.curr);
               errors++;
            end else begin
               want = pending_readings.pop_front();
               if (got !== want) begin
                  $display({"%0t: mismatch expected gate=%0d volt=%0h curr=%0h,",
                            " actual gate=%0d volt=%0h curr=%0h"},
                           $time, want.gate_on, want.volt, want.curr,
                           got.gate_on, got.volt, got.curr);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_volt_sample <= v;
      req_curr_sample <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_run(input logic [SAMPLE_W-1:0] v, input int count);
      repeat (count) send_sample(v, SAMPLE_W'($urandom_range(0, 4095)));
   endtask

   // wait on the clock first so the last accepted request is already queued
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_reg(input logic [dhc_lpf_pkg::IDX_W-1:0] idx,
                            input logic [dhc_lpf_pkg::DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register %0d readback expected %0h actual %0h", $time, idx, want, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [dhc_lpf_pkg::IDX_W-1:0] idx,
                            input logic [dhc_lpf_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         dhc_lpf_pkg::REG_HIGH_THR: high_thr = value[dhc_lpf_pkg::THRESH_W-1:0];
         dhc_lpf_pkg::REG_LOW_THR:  low_thr  = value[dhc_lpf_pkg::THRESH_W-1:0];
         dhc_lpf_pkg::REG_DEB_LEN:  deb_len  = value[dhc_lpf_pkg::LEN_W-1:0];
         dhc_lpf_pkg::REG_ALPHA:    alpha    = value[dhc_lpf_pkg::ALPHA_W-1:0];
         default: ;
      endcase
      check_reg(idx, value);
   endtask

   task automatic apply_config(input int hi, input int lo, input int len, input int a);
      wait_idle();
      write_reg(dhc_lpf_pkg::REG_HIGH_THR, hi);
      write_reg(dhc_lpf_pkg::REG_LOW_THR, lo);
      write_reg(dhc_lpf_pkg::REG_DEB_LEN, len);
      write_reg(dhc_lpf_pkg::REG_ALPHA, a);
   endtask

   // runs of qualifying samples around the current thresholds, with some noise
   task automatic drive_runs(input int count);
      int sent;
      int run_max;
      int run_len;
      int kind;
      sent    = 0;
      run_max = (deb_len + 2 > 70) ? 70 : deb_len + 2;
      while (sent < count) begin
         kind    = $urandom_range(0, 9);
         run_len = (kind < 8) ? $urandom_range(1, run_max) : $urandom_range(1, 5);
         if (run_len > count - sent) run_len = count - sent;
         repeat (run_len) begin
            if (kind < 4)
               send_sample(sample_above(), SAMPLE_W'($urandom_range(0, 4095)));
            else if (kind < 8)
               send_sample(sample_below(), SAMPLE_W'($urandom_range(0, 4095)));
            else
               send_sample(SAMPLE_W'($urandom_range(0, 4095)),
                           SAMPLE_W'($urandom_range(0, 4095)));
         end
         sent += run_len;
      end
   endtask

   task automatic test_register_defaults();
      check_reg(dhc_lpf_pkg::REG_HIGH_THR, dhc_lpf_pkg::DATA_W'(dhc_lpf_pkg::HIGH_THR_RST));
      check_reg(dhc_lpf_pkg::REG_LOW_THR, dhc_lpf_pkg::DATA_W'(dhc_lpf_pkg::LOW_THR_RST));
      check_reg(dhc_lpf_pkg::REG_DEB_LEN, dhc_lpf_pkg::DATA_W'(dhc_lpf_pkg::DEB_LEN_RST));
      check_reg(dhc_lpf_pkg::REG_ALPHA, dhc_lpf_pkg::DATA_W'(dhc_lpf_pkg::ALPHA_RST));
   endtask

   // default thresholds: equal-to-threshold never qualifies, a miss restarts the count
   task automatic test_debounce_sequence();
      send_sample(12'd0, 12'd0);
      send_sample(12'hFFF, 12'hFFF);
      send_run(12'd2731, 1);
      send_run(12'd2732, 3);
      send_run(12'd2000, 1);
      send_run(12'd2732, 4);
      send_run(12'd2712, 1);
      send_run(12'd2711, 4);
   endtask

   task automatic test_special_configs();
      // zero length behaves like one
      apply_config(2731, 2712, 0, 1607);
      send_sample(12'hFFF, 12'd0);
      send_sample(12'd0, 12'hFFF);
      // alpha extremes
      apply_config(2731, 2712, 1, 0);
      send_sample(12'd3000, 12'hFFF);
      send_sample(12'd0, 12'd0);
      apply_config(2731, 2712, 1, 65535);
      send_sample(12'hFFF, 12'hFFF);
      send_sample(12'd0, 12'd0);
      // crossed thresholds used as written
      apply_config(100, 3000, 1, 1607);
      send_sample(12'd200, 12'd5);
      send_sample(12'd2000, 12'd5);
      // run already past a lowered length switches on the next qualifying sample
      apply_config(2731, 2712, 10, 1607);
      send_run(12'd3000, 6);
      apply_config(2731, 2712, 2, 1607);
      send_run(12'd3000, 1);
   endtask

   task automatic test_backpressure();
      apply_config(2000, 1900, 3, 30000);
      long_hold = 1'b1;
      drive_runs(40);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int hi;
      int lo;
      int len;
      apply_config(4095, 0, 255, 65535);
      drive_runs(90);
      apply_config(0, 4095, 0, 0);
      drive_runs(90);
      repeat (6) begin
         hi  = $urandom_range(0, 4095);
         lo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                           : ((hi > 40) ? hi - $urandom_range(0, 40) : 0);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
         apply_config(hi, lo, len, $urandom_range(0, 65535));
         drive_runs(90);
      end
   endtask

   task automatic test_steady_stream();
      idling = 1'b0;
      apply_config(2048, 2000, 2, $urandom_range(0, 65535));
      drive_runs(60);
   endtask

   initial begin
      errors          = 0;
      quiet_cycles    = 0;
      idling          = 1'b1;
      long_hold       = 1'b0;
      high_thr        = dhc_lpf_pkg::HIGH_THR_RST;
      low_thr         = dhc_lpf_pkg::LOW_THR_RST;
      deb_len         = dhc_lpf_pkg::DEB_LEN_RST;
      alpha           = dhc_lpf_pkg::ALPHA_RST;
      gate            = 1'b0;
      above_run       = '0;
      below_run       = '0;
      volt_acc        = '0;
      curr_acc        = '0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_volt_sample = '0;
      req_curr_sample = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_debounce_sequence();
      test_special_configs();
      test_backpressure();
      test_random_phases();
      test_steady_stream();
      wait_idle();

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: debounced_hysteresis_clamp_with_lpf.f
+incdir+sv
sv/dhc_lpf_pkg.sv
sv/debounced_hysteresis_clamp_with_lpf.sv
sim/debounced_hysteresis_clamp_with_lpf_test.sv
